// ===== rtl/core/icv_pkg.sv =====
// Shared constants, types and state codes of the indexed clause vote classifier.
// No dependencies; every file of the block but icv_ram imports this package.
package icv_pkg;

  localparam int CLASSES     = 8;
  localparam int CLAUSES     = 128;
  localparam int LITERALS    = 512;
  localparam int WEIGHT_BITS = 15;
  localparam int WORD_BITS   = 32;
  localparam int CHUNKS      = LITERALS / WORD_BITS;

  localparam int CLASS_W    = $clog2(CLASSES);
  localparam int CLAUSE_W   = $clog2(CLAUSES);
  localparam int LIT_W      = $clog2(LITERALS);
  localparam int CHUNK_W    = $clog2(CHUNKS);
  localparam int WORD_LSB_W = $clog2(WORD_BITS);
  localparam int LEN_W      = $clog2(CLAUSES + 1);
  localparam int CNT_W      = $clog2(LITERALS + 1);
  localparam int SUM_W      = CLAUSE_W + WEIGHT_BITS + 2;
  localparam int WC_W       = WEIGHT_BITS + CNT_W;
  localparam int EPOCH_W    = 8;

  localparam int LIST_AW = CLASS_W + LIT_W + CLAUSE_W;
  localparam int LEN_AW  = CLASS_W + LIT_W;
  localparam int WC_AW   = CLASS_W + CLAUSE_W;

  localparam int THR_W      = 15;
  localparam int CCNT_W     = 4;
  localparam int LCNT_W     = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;
  localparam int OUT_SUM_W  = THR_W + 1;
  localparam int CLAMP_W    = THR_W + 2;

  localparam logic [LEN_W-1:0] POS_ABSENT = '1;

  localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(15);
  localparam logic [CCNT_W-1:0] CCNT_RESET = CCNT_W'(2);
  localparam logic [LCNT_W-1:0] LCNT_RESET = LCNT_W'(512);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_DEL    = 2'd1,
    OP_WEIGHT = 2'd2,
    OP_WORD   = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_CLASSES   = 2'd1,
    CFG_LITERALS  = 2'd2
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_A_RD,
    ST_A_UPD,
    ST_D_RD,
    ST_D_CHK,
    ST_D_MOVE,
    ST_D_FREE,
    ST_W_RD,
    ST_W_SUB,
    ST_W_ADD,
    ST_C_INIT,
    ST_C_WIPE,
    ST_C_LIT,
    ST_C_LEN,
    ST_C_ENT,
    ST_C_J,
    ST_C_W,
    ST_C_CLAMP,
    ST_C_CMP,
    ST_C_DONE
  } state_t;

endpackage

// ===== rtl/core/icv_if.sv =====
// Valid/ready channel interfaces for the input items and the results.
// Depends on icv_pkg for the field widths.
interface icv_in_if import icv_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           operation;
  logic [CLASS_W-1:0]   class_index;
  logic [CLAUSE_W-1:0]  clause_index;
  logic [LIT_W-1:0]     literal_index;
  logic [WEIGHT_BITS-1:0] clause_weight;
  logic [CHUNK_W-1:0]   chunk_index;
  logic [WORD_BITS-1:0] literal_word;
  logic                 end_of_example;

  modport source (output valid, operation, class_index, clause_index, literal_index,
                  clause_weight, chunk_index, literal_word, end_of_example,
                  input ready);
  modport sink (input valid, operation, class_index, clause_index, literal_index,
                clause_weight, chunk_index, literal_word, end_of_example,
                output ready);
endinterface

interface icv_out_if import icv_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [CLASS_W-1:0]          predicted_class;
  logic signed [OUT_SUM_W-1:0] winning_sum;

  modport source (output valid, predicted_class, winning_sum, input ready);
  modport sink (input valid, predicted_class, winning_sum, output ready);
endinterface

// ===== rtl/core/icv_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module icv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/icv_alu.sv =====
// Shared add/subtract unit for class baselines and vote sums.
// Depends on icv_pkg for the sum and weight widths.
module icv_alu import icv_pkg::*; (
  input  logic signed [SUM_W-1:0] a,
  input  logic [WEIGHT_BITS-1:0]  w,
  input  logic                    neg,
  output logic signed [SUM_W-1:0] y
);

  logic signed [SUM_W-1:0] wext;

  assign wext = signed'(SUM_W'(w));
  assign y    = neg ? (a - wext) : (a + wext);

endmodule

// ===== rtl/core/indexed_clause_vote_classifier_unit.sv =====
// Top level of the indexed clause vote classifier: sequencer, stores and result register.
// Depends on icv_pkg, icv_if, icv_ram and icv_alu.
//
//   port        dir   kind                   transaction
//   in_ch       sink  valid/ready item       valid && ready at clk edge
//   out_ch      src   valid/ready result     valid && ready at clk edge
//   cfg_*       in    write enable/index     cfg_wr_en at clk edge
//
// After reset a clearing pass marks every list position absent and zeroes list
// lengths, weights, include counts and clause marks; in_ch.ready stays low. Add runs
// A_RD, A_UPD; delete D_RD, D_CHK and, if present, D_MOVE, D_FREE; weight load W_RD,
// W_SUB, W_ADD; a literal word without end is taken in IDLE. Per class, classification
// runs C_INIT, C_LIT over the literals in use, C_LEN and C_ENT per zero literal, C_J
// and C_W per list entry, serial by the single read port of each store, then C_CLAMP
// and C_CMP; C_DONE loads the result. C_WIPE re-arms the marks every 255 class walks.
// A finished result waits in the output register; the next item is taken meanwhile.
module indexed_clause_vote_classifier_unit import icv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  icv_in_if.sink                in_ch,
  icv_out_if.source             out_ch,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  state_t state, state_next;

  logic [THR_W-1:0]  vote_threshold;
  logic [CCNT_W-1:0] class_count;
  logic [LCNT_W-1:0] literal_count;

  logic [LIST_AW-1:0] clr_cnt;
  logic               out_valid;
  logic [EPOCH_W-1:0] epoch;

  logic signed [SUM_W-1:0] baseline [CLASSES];
  logic [WORD_BITS-1:0]    buffer [CHUNKS];

  // item registers
  logic [CLASS_W-1:0]     c_q;
  logic [CLAUSE_W-1:0]    j_q;
  logic [LIT_W-1:0]       k_q;
  logic [WEIGHT_BITS-1:0] w_q;

  logic [LEN_W-1:0]       len_q;
  logic [LEN_W-1:0]       p_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [WEIGHT_BITS-1:0] wt_q;

  logic signed [SUM_W-1:0]   sum;
  logic [LCNT_W-1:0]         kcnt;
  logic [LEN_W-1:0]          idx;
  logic [CLAUSE_W-1:0]       jc_q;
  logic [CLASS_W-1:0]        cls;
  logic signed [CLAMP_W-1:0] clamp_q;
  logic signed [CLAMP_W-1:0] best;
  logic [CLASS_W-1:0]        best_cls;

  logic [CLASS_W-1:0]          out_class;
  logic signed [OUT_SUM_W-1:0] out_sum;

  // memory ports
  logic                lists_we;
  logic [LIST_AW-1:0]  lists_waddr, lists_raddr;
  logic [CLAUSE_W-1:0] lists_wdata, lists_rdata;
  logic                pos_we;
  logic [LIST_AW-1:0]  pos_waddr, pos_raddr;
  logic [LEN_W-1:0]    pos_wdata, pos_rdata;
  logic                len_we;
  logic [LEN_AW-1:0]   len_waddr, len_raddr;
  logic [LEN_W-1:0]    len_wdata, len_rdata;
  logic                wc_we;
  logic [WC_AW-1:0]    wc_waddr, wc_raddr;
  logic [WC_W-1:0]     wc_wdata, wc_rdata;
  logic                alive_we;
  logic [CLAUSE_W-1:0] alive_waddr, alive_raddr;
  logic [EPOCH_W-1:0]  alive_wdata, alive_rdata;

  logic [WEIGHT_BITS-1:0] wc_weight;
  logic [CNT_W-1:0]       wc_cnt;

  logic signed [SUM_W-1:0] alu_a, alu_y;
  logic [WEIGHT_BITS-1:0]  alu_w;
  logic                    alu_neg;
  logic                    bl_we, sum_we;

  logic                    in_ready;
  logic                    in_accept;
  logic                    add_ok, del_ok;
  logic                    clause_live;
  logic [LCNT_W-1:0]       lits_eff;
  logic [CCNT_W-1:0]       nclass_eff;
  logic                    last_cls;
  logic                    lit_bit;
  logic signed [SUM_W-1:0] thr_s;
  logic signed [SUM_W-1:0] clamp_next;
  logic [LEN_W-1:0]        len_dec;

  assign wc_weight = wc_rdata[WC_W-1:CNT_W];
  assign wc_cnt    = wc_rdata[CNT_W-1:0];

  assign in_accept = in_ch.valid && in_ready;
  assign add_ok    = (pos_rdata == POS_ABSENT) && (len_rdata < LEN_W'(CLAUSES));
  assign del_ok    = (pos_rdata != POS_ABSENT) && (len_rdata != '0) && (pos_rdata < len_rdata);
  assign len_dec   = len_q - LEN_W'(1);
  // a clause is dead for this class walk once its mark equals the current epoch
  assign clause_live = (alive_rdata != epoch);

  assign lits_eff   = (literal_count > LCNT_W'(LITERALS)) ? LCNT_W'(LITERALS) : literal_count;
  assign nclass_eff = (class_count == '0) ? CCNT_W'(1) :
                      (class_count > CCNT_W'(CLASSES)) ? CCNT_W'(CLASSES) : class_count;
  assign last_cls   = (CCNT_W'(cls) == (nclass_eff - CCNT_W'(1)));
  assign lit_bit    = buffer[kcnt[LIT_W-1:WORD_LSB_W]][kcnt[WORD_LSB_W-1:0]];

  assign thr_s      = signed'(SUM_W'(vote_threshold));
  assign clamp_next = (sum > thr_s) ? thr_s : ((sum < -thr_s) ? -thr_s : sum);

  icv_ram #(.WIDTH(CLAUSE_W), .DEPTH(CLASSES * LITERALS * CLAUSES)) u_lists (
    .clk, .wr_en(lists_we), .wr_addr(lists_waddr), .wr_data(lists_wdata),
    .rd_addr(lists_raddr), .rd_data(lists_rdata)
  );

  icv_ram #(.WIDTH(LEN_W), .DEPTH(CLASSES * LITERALS * CLAUSES)) u_pos (
    .clk, .wr_en(pos_we), .wr_addr(pos_waddr), .wr_data(pos_wdata),
    .rd_addr(pos_raddr), .rd_data(pos_rdata)
  );

  icv_ram #(.WIDTH(LEN_W), .DEPTH(CLASSES * LITERALS)) u_len (
    .clk, .wr_en(len_we), .wr_addr(len_waddr), .wr_data(len_wdata),
    .rd_addr(len_raddr), .rd_data(len_rdata)
  );

  icv_ram #(.WIDTH(WC_W), .DEPTH(CLASSES * CLAUSES)) u_wc (
    .clk, .wr_en(wc_we), .wr_addr(wc_waddr), .wr_data(wc_wdata),
    .rd_addr(wc_raddr), .rd_data(wc_rdata)
  );

  icv_ram #(.WIDTH(EPOCH_W), .DEPTH(CLAUSES)) u_alive (
    .clk, .wr_en(alive_we), .wr_addr(alive_waddr), .wr_data(alive_wdata),
    .rd_addr(alive_raddr), .rd_data(alive_rdata)
  );

  icv_alu u_alu (.a(alu_a), .w(alu_w), .neg(alu_neg), .y(alu_y));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:   if (clr_cnt == '1) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_accept) begin
          case (op_t'(in_ch.operation))
            OP_ADD:    state_next = ST_A_RD;
            OP_DEL:    state_next = ST_D_RD;
            OP_WEIGHT: state_next = ST_W_RD;
            default:   state_next = in_ch.end_of_example ? ST_C_INIT : ST_IDLE;
          endcase
        end
      end
      ST_A_RD:    state_next = ST_A_UPD;
      ST_A_UPD:   state_next = ST_IDLE;
      ST_D_RD:    state_next = ST_D_CHK;
      ST_D_CHK:   state_next = del_ok ? ST_D_MOVE : ST_IDLE;
      ST_D_MOVE:  state_next = ST_D_FREE;
      ST_D_FREE:  state_next = ST_IDLE;
      ST_W_RD:    state_next = ST_W_SUB;
      ST_W_SUB:   state_next = ST_W_ADD;
      ST_W_ADD:   state_next = ST_IDLE;
      ST_C_INIT:  state_next = (epoch == '1) ? ST_C_WIPE : ST_C_LIT;
      ST_C_WIPE:  if (clr_cnt[CLAUSE_W-1:0] == '1) state_next = ST_C_LIT;
      ST_C_LIT: begin
        if (kcnt == lits_eff) state_next = ST_C_CLAMP;
        else if (!lit_bit)    state_next = ST_C_LEN;
      end
      ST_C_LEN:   state_next = ST_C_ENT;
      ST_C_ENT:   state_next = (idx == len_q) ? ST_C_LIT : ST_C_J;
      ST_C_J:     state_next = ST_C_W;
      ST_C_W:     state_next = ST_C_ENT;
      ST_C_CLAMP: state_next = ST_C_CMP;
      ST_C_CMP:   state_next = last_cls ? ST_C_DONE : ST_C_INIT;
      ST_C_DONE:  if (!out_valid || out_ch.ready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer: memory ports and shared unit operands
  always_comb begin
    in_ready    = 1'b0;
    lists_we    = 1'b0;
    lists_waddr = {c_q, k_q, len_rdata[CLAUSE_W-1:0]};
    lists_wdata = j_q;
    lists_raddr = {cls, kcnt[LIT_W-1:0], idx[CLAUSE_W-1:0]};
    pos_we      = 1'b0;
    pos_waddr   = {c_q, k_q, j_q};
    pos_wdata   = POS_ABSENT;
    pos_raddr   = {c_q, k_q, j_q};
    len_we      = 1'b0;
    len_waddr   = {c_q, k_q};
    len_wdata   = LEN_W'(len_rdata + LEN_W'(1));
    len_raddr   = {c_q, k_q};
    wc_we       = 1'b0;
    wc_waddr    = {c_q, j_q};
    wc_wdata    = {wc_weight, CNT_W'(wc_cnt + CNT_W'(1))};
    wc_raddr    = {c_q, j_q};
    alive_we    = 1'b0;
    alive_waddr = jc_q;
    alive_wdata = epoch;
    alive_raddr = lists_rdata;
    alu_a       = baseline[c_q];
    alu_w       = wc_weight;
    alu_neg     = j_q[0];
    bl_we       = 1'b0;
    sum_we      = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        pos_we      = 1'b1;
        pos_waddr   = clr_cnt;
        len_we      = 1'b1;
        len_waddr   = clr_cnt[LEN_AW-1:0];
        len_wdata   = '0;
        wc_we       = 1'b1;
        wc_waddr    = clr_cnt[WC_AW-1:0];
        wc_wdata    = '0;
        alive_we    = 1'b1;
        alive_waddr = clr_cnt[CLAUSE_W-1:0];
        alive_wdata = '0;
      end
      ST_IDLE: in_ready = 1'b1;
      ST_A_UPD: begin
        if (add_ok) begin
          lists_we  = 1'b1;
          pos_we    = 1'b1;
          pos_wdata = len_rdata;
          len_we    = 1'b1;
          wc_we     = 1'b1;
          bl_we     = (wc_cnt == '0);
        end
      end
      ST_D_CHK: lists_raddr = {c_q, k_q, CLAUSE_W'(len_rdata - LEN_W'(1))};
      ST_D_MOVE: begin
        // move the last entry into the hole unless the hole is the last entry
        if (p_q != len_dec) begin
          lists_we    = 1'b1;
          lists_waddr = {c_q, k_q, p_q[CLAUSE_W-1:0]};
          lists_wdata = lists_rdata;
          pos_we      = 1'b1;
          pos_waddr   = {c_q, k_q, lists_rdata};
          pos_wdata   = p_q;
        end
        len_we    = 1'b1;
        len_wdata = len_dec;
        wc_we     = (cnt_q != '0);
        wc_wdata  = {wt_q, CNT_W'(cnt_q - CNT_W'(1))};
        alu_w     = wt_q;
        alu_neg   = !j_q[0];
        bl_we     = (cnt_q == CNT_W'(1));
      end
      ST_D_FREE: pos_we = 1'b1;
      ST_W_SUB: begin
        alu_neg = !j_q[0];
        bl_we   = (wc_cnt != '0);
      end
      ST_W_ADD: begin
        wc_we    = 1'b1;
        wc_wdata = {w_q, cnt_q};
        alu_w    = w_q;
        bl_we    = (cnt_q != '0);
      end
      ST_C_WIPE: begin
        alive_we    = 1'b1;
        alive_waddr = clr_cnt[CLAUSE_W-1:0];
        alive_wdata = '0;
      end
      ST_C_LIT: len_raddr = {cls, kcnt[LIT_W-1:0]};
      ST_C_J:   wc_raddr  = {cls, lists_rdata};
      ST_C_W: begin
        alu_a    = sum;
        alu_neg  = !jc_q[0];
        sum_we   = clause_live;
        alive_we = clause_live;
      end
      default: ;
    endcase
  end

  // control state and stores cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_cnt        <= '0;
      out_valid      <= 1'b0;
      epoch          <= '0;
      vote_threshold <= THR_RESET;
      class_count    <= CCNT_RESET;
      literal_count  <= LCNT_RESET;
      for (int i = 0; i < CLASSES; i++) begin
        baseline[i] <= '0;
      end
      for (int i = 0; i < CHUNKS; i++) begin
        buffer[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == ST_CLEAR || state == ST_C_WIPE) begin
        clr_cnt <= clr_cnt + LIST_AW'(1);
      end
      // advance the epoch per class walk; restart at one after the marks are wiped
      if (state == ST_C_INIT && epoch != '1) begin
        epoch <= epoch + EPOCH_W'(1);
      end
      if (state == ST_C_WIPE && clr_cnt[CLAUSE_W-1:0] == '1) begin
        epoch <= EPOCH_W'(1);
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_THRESHOLD: vote_threshold <= cfg_data[THR_W-1:0];
          CFG_CLASSES:   class_count    <= cfg_data[CCNT_W-1:0];
          CFG_LITERALS:  literal_count  <= cfg_data[LCNT_W-1:0];
          default: ;
        endcase
      end
      if (bl_we) begin
        baseline[c_q] <= alu_y;
      end
      if (in_accept && op_t'(in_ch.operation) == OP_WORD) begin
        buffer[in_ch.chunk_index] <= in_ch.literal_word;
      end
      if (state == ST_C_DONE && (!out_valid || out_ch.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      c_q      <= in_ch.class_index;
      j_q      <= in_ch.clause_index;
      k_q      <= in_ch.literal_index;
      w_q      <= in_ch.clause_weight;
      cls      <= '0;
      best     <= ~signed'(CLAMP_W'(vote_threshold));
    end
    if (sum_we) begin
      sum <= alu_y;
    end
    case (state)
      ST_D_CHK: begin
        len_q <= len_rdata;
        p_q   <= pos_rdata;
        cnt_q <= wc_cnt;
        wt_q  <= wc_weight;
      end
      ST_W_SUB: begin
        cnt_q <= wc_cnt;
        wt_q  <= wc_weight;
      end
      ST_C_INIT: begin
        sum   <= baseline[cls];
        kcnt  <= '0;
      end
      ST_C_LIT: begin
        if (kcnt != lits_eff && lit_bit) kcnt <= kcnt + LCNT_W'(1);
      end
      ST_C_LEN: begin
        len_q <= len_rdata;
        idx   <= '0;
      end
      ST_C_ENT: begin
        if (idx == len_q) kcnt <= kcnt + LCNT_W'(1);
      end
      ST_C_J: jc_q <= lists_rdata;
      ST_C_W: idx <= idx + LEN_W'(1);
      ST_C_CLAMP: clamp_q <= clamp_next[CLAMP_W-1:0];
      ST_C_CMP: begin
        if (best < clamp_q) begin
          best     <= clamp_q;
          best_cls <= cls;
        end
        if (!last_cls) cls <= cls + CLASS_W'(1);
      end
      ST_C_DONE: begin
        if (!out_valid || out_ch.ready) begin
          out_class <= best_cls;
          out_sum   <= best[OUT_SUM_W-1:0];
        end
      end
      default: ;
    endcase
  end

  assign in_ch.ready            = in_ready;
  assign out_ch.valid           = out_valid;
  assign out_ch.predicted_class = out_class;
  assign out_ch.winning_sum     = out_sum;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready && (in_ch.operation != OP_WORD || in_ch.end_of_example)
    |=> !in_ch.ready)
    else $error("input taken while an item is still in work");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(state) == ST_C_DONE)
    else $error("result raised outside the final step of classification");

  a_epoch_armed: assert property (@(posedge clk) disable iff (rst)
    state == ST_C_LIT |-> epoch != '0)
    else $error("list walk started without a fresh clause epoch");

endmodule

// ===== sim/indexed_clause_vote_classifier_unit_test.sv =====
// Self-checking testbench of the indexed clause vote classifier unit.
// Uses icv_pkg, icv_in_if, icv_out_if and the unit; an in-bench vote predictor checks results.
module indexed_clause_vote_classifier_unit_test;
  import icv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CLASS_W-1:0]          cls;
    logic signed [OUT_SUM_W-1:0] sum;
  } vote_result_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  icv_in_if  in_ch ();
  icv_out_if out_ch ();

  indexed_clause_vote_classifier_unit uut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic [CLAUSE_W-1:0] lst_entry [CLASSES*LITERALS][CLAUSES];
  logic [LEN_W-1:0]    lst_pos   [CLASSES*LITERALS][CLAUSES];
  int                  lst_len   [CLASSES*LITERALS];
  int                  clause_wt [CLASSES*CLAUSES];
  int                  inc_count [CLASSES*CLAUSES];
  longint              baseline  [CLASSES];
  logic [31:0]         word_buf  [CHUNKS];
  int                  thr_reg, ccnt_reg, lcnt_reg;

  vote_result_t pending_votes[$];
  int send_idle, recv_idle;
  int mismatches, items_sent, votes_seen, configs_done;
  bit failed;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #60000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk) begin
    out_ch.ready <= (rst == 1'b0) && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    vote_result_t exp_v;
    if (!rst && out_ch.valid && out_ch.ready) begin
      votes_seen++;
      if (pending_votes.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result class %0d sum %0d", out_ch.predicted_class,
                   out_ch.winning_sum);
      end else begin
        exp_v = pending_votes.pop_front();
        if (exp_v.cls !== out_ch.predicted_class || exp_v.sum !== out_ch.winning_sum) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("vote mismatch: expected class %0d sum %0d, got class %0d sum %0d",
                     exp_v.cls, exp_v.sum, out_ch.predicted_class, out_ch.winning_sum);
        end
      end
    end
  end

  function automatic longint signed_wt(int c, int j);
    longint w;
    w = clause_wt[c*CLAUSES+j];
    return (j % 2) ? -w : w;
  endfunction

  function automatic void model_add(int c, int j, int k);
    int l, n;
    l = c*LITERALS + k;
    n = lst_len[l];
    if (lst_pos[l][j] != POS_ABSENT || n >= CLAUSES) return;
    lst_entry[l][n] = CLAUSE_W'(j);
    lst_pos[l][j] = LEN_W'(n);
    lst_len[l] = n + 1;
    if (inc_count[c*CLAUSES+j] == 0) baseline[c] += signed_wt(c, j);
    inc_count[c*CLAUSES+j]++;
  endfunction

  function automatic void model_delete(int c, int j, int k);
    int l, n, p, moved;
    l = c*LITERALS + k;
    n = lst_len[l];
    p = int'(lst_pos[l][j]);
    if (lst_pos[l][j] == POS_ABSENT || n == 0 || p >= n) return;
    // swap the last entry into the hole
    if (p != n - 1) begin
      moved = int'(lst_entry[l][n-1]);
      lst_entry[l][p] = CLAUSE_W'(moved);
      lst_pos[l][moved] = LEN_W'(p);
    end
    lst_len[l] = n - 1;
    lst_pos[l][j] = POS_ABSENT;
    if (inc_count[c*CLAUSES+j] > 0) begin
      inc_count[c*CLAUSES+j]--;
      if (inc_count[c*CLAUSES+j] == 0) baseline[c] -= signed_wt(c, j);
    end
  endfunction

  function automatic void model_weight(int c, int j, int w);
    if (inc_count[c*CLAUSES+j] > 0) baseline[c] -= signed_wt(c, j);
    clause_wt[c*CLAUSES+j] = w;
    if (inc_count[c*CLAUSES+j] > 0) baseline[c] += signed_wt(c, j);
  endfunction

  function automatic vote_result_t predict_vote();
    vote_result_t r;
    int nc, lits, bc, l, j;
    longint t, best, s;
    bit alive [CLAUSES];
    nc = (ccnt_reg == 0) ? 1 : (ccnt_reg > CLASSES ? CLASSES : ccnt_reg);
    lits = (lcnt_reg > LITERALS) ? LITERALS : lcnt_reg;
    t = thr_reg;
    best = -t - 1;
    bc = 0;
    for (int c = 0; c < nc; c++) begin
      s = baseline[c];
      foreach (alive[i]) alive[i] = 1'b1;
      for (int k = 0; k < lits; k++) begin
        if (word_buf[k/32][k%32]) continue;
        l = c*LITERALS + k;
        for (int i = 0; i < lst_len[l]; i++) begin
          j = int'(lst_entry[l][i]);
          if (alive[j]) begin
            s -= signed_wt(c, j);
            alive[j] = 1'b0;
          end
        end
      end
      if (s > t) s = t;
      if (s < -t) s = -t;
      if (best < s) begin
        best = s;
        bc = c;
      end
    end
    r.cls = CLASS_W'(bc);
    r.sum = OUT_SUM_W'(best);
    return r;
  endfunction

  task automatic send_item(op_t op, int c, int j, int k, int w, int ch,
                           logic [31:0] word, bit eoe);
    if ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.class_index <= CLASS_W'(c);
    in_ch.clause_index <= CLAUSE_W'(j);
    in_ch.literal_index <= LIT_W'(k);
    in_ch.clause_weight <= WEIGHT_BITS'(w);
    in_ch.chunk_index <= CHUNK_W'(ch);
    in_ch.literal_word <= word;
    in_ch.end_of_example <= eoe;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    case (op)
      OP_ADD:    model_add(c, j, k);
      OP_DEL:    model_delete(c, j, k);
      OP_WEIGHT: model_weight(c, j, w);
      OP_WORD: begin
        word_buf[ch] = word;
        if (eoe) pending_votes.push_back(predict_vote());
      end
    endcase
  endtask

  // hold until every vote is back and list updates have settled
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_votes.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, int value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    @(posedge clk);
    case (idx)
      CFG_THRESHOLD: thr_reg = value & 16'h7FFF;
      CFG_CLASSES:   ccnt_reg = value & 4'hF;
      CFG_LITERALS:  lcnt_reg = value & 10'h3FF;
    endcase
    configs_done++;
  endtask

  task automatic set_config(int thr, int cc, int lc);
    drain();
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_CLASSES, cc);
    write_reg(CFG_LITERALS, lc);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic test_directed_cases();
    send_item(OP_WEIGHT, 0, 0, 0, 32767, 0, 0, 0);
    send_item(OP_WEIGHT, 0, 1, 0, 200, 0, 0, 0);
    send_item(OP_WEIGHT, 7, 127, 0, 32767, 0, 0, 0);
    send_item(OP_ADD, 0, 0, 0, 0, 0, 0, 0);
    send_item(OP_ADD, 0, 0, 0, 0, 0, 0, 0);         // duplicate add
    send_item(OP_ADD, 0, 1, 0, 0, 0, 0, 0);
    send_item(OP_ADD, 0, 2, 0, 0, 0, 0, 0);
    send_item(OP_ADD, 1, 3, 511, 0, 0, 0, 0);
    send_item(OP_ADD, 7, 127, 511, 0, 0, 0, 0);
    send_item(OP_DEL, 0, 5, 0, 0, 0, 0, 0);         // absent delete
    send_item(OP_DEL, 0, 0, 0, 0, 0, 0, 0);         // last entry fills the hole
    send_item(OP_WEIGHT, 0, 1, 0, 0, 0, 0, 0);      // reload on a non-empty clause
    send_item(OP_WEIGHT, 1, 3, 0, 12345, 0, 0, 0);
    send_item(OP_WORD, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 0);
    send_item(OP_WORD, 0, 0, 0, 0, 15, 32'h0000_0000, 1);
    send_item(OP_WORD, 0, 0, 0, 0, 0, 32'h0000_0000, 1);
    send_item(OP_WORD, 0, 0, 0, 0, 15, 32'hFFFF_FFFF, 1);
    send_item(OP_ADD, 0, 0, 0, 0, 0, 0, 0);
    send_item(OP_WORD, 0, 0, 0, 0, 0, 32'hFFFF_FFFE, 1);
  endtask

  task automatic test_random_traffic(int count, int lc, bit hold_mid);
    int r, span, k;
    logic [31:0] word;
    span = (lc < 1) ? 1 : (lc > 64 ? 64 : lc);
    for (int n = 0; n < count; n++) begin
      if (hold_mid && n == count/2) drain();
      r = $urandom_range(99);
      k = ($urandom_range(9) < 8) ? $urandom_range(span-1) : $urandom_range(LITERALS-1);
      if (r < 35)
        send_item(OP_ADD, $urandom_range(7), $urandom_range(127), k, 0, 0, 0, 0);
      else if (r < 55)
        send_item(OP_DEL, $urandom_range(7), $urandom_range(127), k, 0, 0, 0, 0);
      else if (r < 70)
        send_item(OP_WEIGHT, $urandom_range(7), $urandom_range(127), 0,
                  ($urandom_range(3) == 0) ? $urandom_range(32767) : $urandom_range(300),
                  0, 0, 0);
      else begin
        // mostly ones so that some clauses survive
        word = ($urandom_range(3) == 0) ? $urandom() : ($urandom() | $urandom());
        send_item(OP_WORD, $urandom_range(7), $urandom_range(127), $urandom_range(511),
                  $urandom_range(32767),
                  ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range((span-1)/32),
                  word, $urandom_range(9) < 4);
      end
      if (n % 90 == 0) begin
        if (items_sent < 470) begin
          send_idle = 28; recv_idle = 56;
        end else if (items_sent < 930) begin
          send_idle = 56; recv_idle = 28;
        end else begin
          send_idle = 0; recv_idle = 0;
        end
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = '0;
    in_ch.class_index = '0;
    in_ch.clause_index = '0;
    in_ch.literal_index = '0;
    in_ch.clause_weight = '0;
    in_ch.chunk_index = '0;
    in_ch.literal_word = '0;
    in_ch.end_of_example = 1'b0;
    out_ch.ready = 1'b0;
    send_idle = 28;
    recv_idle = 56;
    thr_reg = 15; ccnt_reg = 2; lcnt_reg = 512;
    for (int l = 0; l < CLASSES*LITERALS; l++) begin
      lst_len[l] = 0;
      for (int j = 0; j < CLAUSES; j++) begin
        lst_pos[l][j] = POS_ABSENT;
        lst_entry[l][j] = '0;
      end
    end
    foreach (clause_wt[i]) begin
      clause_wt[i] = 0;
      inc_count[i] = 0;
    end
    foreach (baseline[i]) baseline[i] = 0;
    foreach (word_buf[i]) word_buf[i] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_random_traffic(220, 512, 1'b0);
    set_config(32767, 8, 64);
    test_random_traffic(230, 64, 1'b1);
    set_config(1, 1, 1);
    test_random_traffic(200, 1, 1'b0);
    set_config(0, 15, 1023);
    test_random_traffic(200, 512, 1'b0);
    set_config(300, 0, 0);
    test_random_traffic(150, 0, 1'b0);
    set_config(5000, 5, 96);
    test_random_traffic(350, 96, 1'b0);
    drain();

    $display("sent %0d items, checked %0d votes over %0d register writes", items_sent,
             votes_seen, configs_done);
    $display("covered list add/delete, weight loads and clamped argmax under six settings");
    if (!failed && mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/core/icv_pkg.sv
rtl/core/icv_if.sv
rtl/core/icv_ram.sv
rtl/core/icv_alu.sv
rtl/core/indexed_clause_vote_classifier_unit.sv
sim/indexed_clause_vote_classifier_unit_test.sv
